>>> rtl/efds_pkg.sv
// shared types and constants for the event fifo with drop summary
package efds_pkg;

    localparam int SLOTS  = 256;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int PTR_W  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_IDENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUMMARY_KIND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSSY_FLAG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING      = 3'd5;

    typedef enum logic [1:0] {
        OP_PUBLISH = 2'd0,
        OP_POP     = 2'd1,
        OP_SUMMARY = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    typedef struct packed {
        logic        enabled;
        logic [31:0] stream_ident;
        logic [7:0]  capacity_in_use;
        logic [31:0] summary_kind_code;
        logic [31:0] lossy_flag_code;
        logic [31:0] warning_code;
    } cfg_t;

    // first field of the stream item sits in the lowest bits
    typedef struct packed {
        logic [31:0] lost_kind;
        logic [63:0] value_c;
        logic [63:0] value_b;
        logic [63:0] value_a;
        logic [31:0] reason;
        logic [31:0] flag_bits;
        logic [31:0] kind;
        logic [63:0] time_ns;
        op_t         op;
    } in_item_t;

    typedef struct packed {
        logic [63:0] dropped_total;
        logic [63:0] out_value_c;
        logic [63:0] out_value_b;
        logic [63:0] out_value_a;
        logic [31:0] out_reason;
        logic [31:0] out_flags;
        logic [31:0] out_kind;
        logic [63:0] out_time;
        logic [63:0] out_seq;
        logic [31:0] out_stream;
        logic        event_valid;
        logic        accepted;
    } result_t;

    typedef struct packed {
        logic [63:0] value_c;
        logic [63:0] value_b;
        logic [63:0] value_a;
        logic [31:0] reason;
        logic [31:0] flags;
        logic [31:0] kind;
        logic [63:0] time_ns;
        logic [63:0] seq;
        logic [31:0] stream;
    } slot_t;

    localparam int IN_BITS   = $bits(in_item_t);
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int RES_BITS  = $bits(result_t);
    localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int SLOT_BITS = $bits(slot_t);

endpackage

>>> rtl/event_fifo_with_drop_summary_unit.sv
// top level of the event fifo with drop summary
// results: publish, summary and failed items give their result in the cycle after accept;
//   a successful pop goes through the registered slot memory read, then the output register
// rate: one item per cycle while the output register can take a result; the registered
//   read of the slot memory holds the input for a successful pop until its result is built
// reset: rst_n clears pointers, counters, configuration and the output valid flag;
//   slot memory contents are not cleared and need no clearing pass
module event_fifo_with_drop_summary_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // op, time_ns, kind, flag_bits, reason, value_a, value_b, value_c, lost_kind
    input  logic [efds_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // accepted, event_valid, out_stream, out_seq, out_time, out_kind, out_flags,
    // out_reason, out_value_a, out_value_b, out_value_c, dropped_total
    output logic [efds_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [efds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data
);

    efds_pkg::cfg_t     cfg;
    efds_pkg::in_item_t in_item;
    efds_pkg::result_t  res;
    logic               res_valid;
    logic               out_free;

    efds_pkg::result_t  out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;

    assign in_item  = efds_pkg::in_item_t'(s_tdata[efds_pkg::IN_BITS-1:0]);
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(efds_pkg::OUT_DATA_W - efds_pkg::RES_BITS){1'b0}}, out_data_reg};

    efds_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    efds_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register holds a result until the downstream side takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

>>> rtl/efds_ram.sv
// generic single-port-write, single-port-read ram with registered read
module efds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/efds_cfg_regs.sv
// configuration register file
module efds_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [efds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    output efds_pkg::cfg_t                     cfg
);

    efds_pkg::cfg_t cfg_reg;
    efds_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                efds_pkg::CFG_ENABLED:      cfg_next.enabled           = cfg_data[0];
                efds_pkg::CFG_STREAM_IDENT: cfg_next.stream_ident      = cfg_data;
                efds_pkg::CFG_CAPACITY:     cfg_next.capacity_in_use   = cfg_data[7:0];
                efds_pkg::CFG_SUMMARY_KIND: cfg_next.summary_kind_code = cfg_data;
                efds_pkg::CFG_LOSSY_FLAG:   cfg_next.lossy_flag_code   = cfg_data;
                efds_pkg::CFG_WARNING:      cfg_next.warning_code      = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/efds_core.sv
// queue control: pointers, counters, slot memory access and result build
module efds_core (
    input  logic                clk,
    input  logic                rst_n,
    input  efds_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  efds_pkg::in_item_t  in_item,
    input  logic                out_free,
    output logic                res_valid,
    output efds_pkg::result_t   res
);

    efds_pkg::state_t state_reg, state_next;
    logic [efds_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [efds_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [63:0] seq_reg, seq_next;
    logic [63:0] drops_total_reg, drops_total_next;
    logic [63:0] drops_pending_reg, drops_pending_next;

    logic                            in_fire;
    logic                            ram_we;
    logic                            ram_re;
    logic [efds_pkg::ADDR_W-1:0]     ram_waddr;
    logic [efds_pkg::ADDR_W-1:0]     ram_raddr;
    efds_pkg::slot_t                 ram_wdata;
    logic [efds_pkg::SLOT_BITS-1:0]  ram_rdata;
    efds_pkg::slot_t                 rd_slot;
    logic [efds_pkg::PTR_W-1:0]      wr_step;
    logic [efds_pkg::PTR_W-1:0]      rd_step;
    logic [63:0]                     seq_inc;

    assign in_ready = (state_reg == efds_pkg::ST_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign rd_slot  = efds_pkg::slot_t'(ram_rdata);
    assign seq_inc  = seq_reg + 64'd1;

    // pointer steps to 0 once it reaches the capacity, else wraps at 8 bits
    assign wr_step = (wr_ptr_reg == cfg.capacity_in_use) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_step = (rd_ptr_reg == cfg.capacity_in_use) ? '0 : rd_ptr_reg + 1'b1;

    assign ram_waddr = wr_ptr_reg[efds_pkg::ADDR_W-1:0];
    assign ram_raddr = rd_ptr_reg[efds_pkg::ADDR_W-1:0];

    always_comb
    begin
        ram_wdata         = '0;
        ram_wdata.stream  = cfg.stream_ident;
        ram_wdata.seq     = seq_inc;
        ram_wdata.time_ns = in_item.time_ns;
        ram_wdata.kind    = in_item.kind;
        ram_wdata.flags   = in_item.flag_bits;
        ram_wdata.reason  = in_item.reason;
        ram_wdata.value_a = in_item.value_a;
        ram_wdata.value_b = in_item.value_b;
        ram_wdata.value_c = in_item.value_c;
    end

    always_comb
    begin
        state_next         = state_reg;
        rd_ptr_next        = rd_ptr_reg;
        wr_ptr_next        = wr_ptr_reg;
        seq_next           = seq_reg;
        drops_total_next   = drops_total_reg;
        drops_pending_next = drops_pending_reg;
        ram_we             = 1'b0;
        ram_re             = 1'b0;
        res_valid          = 1'b0;
        res                = '0;

        unique case (state_reg)
            efds_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_valid = 1'b1;
                    if (cfg.enabled)
                    begin
                        unique case (in_item.op)
                            efds_pkg::OP_PUBLISH:
                            begin
                                seq_next = seq_inc;
                                if (cfg.capacity_in_use == '0 || wr_step == rd_ptr_reg)
                                begin
                                    drops_total_next   = drops_total_reg + 64'd1;
                                    drops_pending_next = drops_pending_reg + 64'd1;
                                end
                                else
                                begin
                                    ram_we       = 1'b1;
                                    wr_ptr_next  = wr_step;
                                    res.accepted = 1'b1;
                                end
                            end
                            efds_pkg::OP_POP:
                            begin
                                if (cfg.capacity_in_use != '0 && rd_ptr_reg != wr_ptr_reg)
                                begin
                                    // result comes out of the memory next cycle
                                    ram_re      = 1'b1;
                                    rd_ptr_next = rd_step;
                                    res_valid   = 1'b0;
                                    state_next  = efds_pkg::ST_READ;
                                end
                            end
                            efds_pkg::OP_SUMMARY:
                            begin
                                if (drops_pending_reg != '0)
                                begin
                                    drops_pending_next = '0;
                                    seq_next           = seq_inc;
                                    res.accepted       = 1'b1;
                                    res.event_valid    = 1'b1;
                                    res.out_stream     = cfg.stream_ident;
                                    res.out_seq        = seq_inc;
                                    res.out_time       = in_item.time_ns;
                                    res.out_kind       = cfg.summary_kind_code;
                                    res.out_flags      = cfg.lossy_flag_code;
                                    res.out_reason     = cfg.warning_code;
                                    res.out_value_a    = drops_pending_reg;
                                    res.out_value_b    = drops_total_reg;
                                    res.out_value_c    = {32'd0, in_item.lost_kind};
                                end
                            end
                            efds_pkg::OP_UNUSED:
                            begin
                                res.accepted = 1'b0;
                            end
                            default:
                            begin
                                res.accepted = 1'b0;
                            end
                        endcase
                        res.dropped_total = drops_total_next;
                    end
                end
            end
            efds_pkg::ST_READ:
            begin
                res_valid         = 1'b1;
                res.accepted      = 1'b1;
                res.event_valid   = 1'b1;
                res.out_stream    = rd_slot.stream;
                res.out_seq       = rd_slot.seq;
                res.out_time      = rd_slot.time_ns;
                res.out_kind      = rd_slot.kind;
                res.out_flags     = rd_slot.flags;
                res.out_reason    = rd_slot.reason;
                res.out_value_a   = rd_slot.value_a;
                res.out_value_b   = rd_slot.value_b;
                res.out_value_c   = rd_slot.value_c;
                res.dropped_total = drops_total_reg;
                state_next        = efds_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = efds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= efds_pkg::ST_IDLE;
            rd_ptr_reg        <= '0;
            wr_ptr_reg        <= '0;
            seq_reg           <= '0;
            drops_total_reg   <= '0;
            drops_pending_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            rd_ptr_reg        <= rd_ptr_next;
            wr_ptr_reg        <= wr_ptr_next;
            seq_reg           <= seq_next;
            drops_total_reg   <= drops_total_next;
            drops_pending_reg <= drops_pending_next;
        end
    end

    efds_ram #(
        .WIDTH (efds_pkg::SLOT_BITS),
        .DEPTH (efds_pkg::SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // a memory read cycle only ever follows an accepted pop
    a_read_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == efds_pkg::ST_READ) |-> $past(ram_re))
        else $error("read state without a pop read");

    // no new item while a pop is still reading the memory
    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == efds_pkg::ST_READ) |-> !in_ready && res_valid)
        else $error("item taken during memory read");

    // write and read of the slot memory never share a cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("slot memory read and write together");

    // an enabled publish always uses a sequence number
    a_publish_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cfg.enabled && in_item.op == efds_pkg::OP_PUBLISH)
        |=> seq_reg == $past(seq_inc))
        else $error("publish did not advance the sequence number");

    // pending drops rise only together with a one-step rise of the total drops
    a_drop_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (drops_pending_next != drops_pending_reg && drops_pending_next != '0)
        |-> drops_total_next == drops_total_reg + 64'd1)
        else $error("pending drop rose without the total");
`endif

endmodule

>>> dv/tb.sv
// testbench: directed and random publish, pop and summary items checked against a queue predictor
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int FILL_RAND    = 0;
    localparam int FILL_ZERO    = 1;
    localparam int FILL_ONES    = 2;
    localparam logic [efds_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic                            clk;
    logic                            rst_n;
    logic [efds_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [efds_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [efds_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [31:0]                     cfg_data;

    // predictor copy of the configuration and queue state
    logic        pred_enabled      = 1'b0;
    logic [31:0] pred_stream       = '0;
    logic [7:0]  pred_cap          = '0;
    logic [31:0] pred_sum_kind     = '0;
    logic [31:0] pred_lossy        = '0;
    logic [31:0] pred_warn         = '0;
    logic [7:0]  pred_rd           = '0;
    logic [7:0]  pred_wr           = '0;
    logic [63:0] pred_seq          = '0;
    logic [63:0] pred_drops_total  = '0;
    logic [63:0] pred_drops_pend   = '0;
    efds_pkg::slot_t slot_mem [efds_pkg::SLOTS];

    efds_pkg::result_t  expected_events [$];
    efds_pkg::in_item_t pending_items [$];

    int  n_errors     = 0;
    int  n_items      = 0;
    int  n_reg_writes = 0;
    int  n_stored     = 0;
    int  n_delivered  = 0;
    int  n_summaries  = 0;
    int  cycle_count  = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  hold_request = 0;
    bit  no_idle      = 1'b0;
    bit  item_taken   = 1'b0;

    event_fifo_with_drop_summary_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] advance_ptr(logic [7:0] p);
        return (p == pred_cap) ? 8'd0 : p + 8'd1;
    endfunction

    function automatic void queue_item(efds_pkg::in_item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic efds_pkg::result_t apply_event_item(efds_pkg::in_item_t it);
        efds_pkg::result_t r;
        efds_pkg::slot_t   e;
        logic [7:0]        nxt;
        r = '0;
        if (!pred_enabled)
            return r;
        case (it.op)
            efds_pkg::OP_PUBLISH:
            begin
                // the sequence number is used even when the event is dropped
                pred_seq = pred_seq + 64'd1;
                nxt = advance_ptr(pred_wr);
                if (pred_cap == 8'd0 || nxt == pred_rd)
                begin
                    pred_drops_total = pred_drops_total + 64'd1;
                    pred_drops_pend  = pred_drops_pend + 64'd1;
                end
                else
                begin
                    e.stream  = pred_stream;
                    e.seq     = pred_seq;
                    e.time_ns = it.time_ns;
                    e.kind    = it.kind;
                    e.flags   = it.flag_bits;
                    e.reason  = it.reason;
                    e.value_a = it.value_a;
                    e.value_b = it.value_b;
                    e.value_c = it.value_c;
                    slot_mem[pred_wr] = e;
                    pred_wr = nxt;
                    r.accepted = 1'b1;
                    n_stored++;
                end
            end
            efds_pkg::OP_POP:
            begin
                if (pred_cap != 8'd0 && pred_rd != pred_wr)
                begin
                    e = slot_mem[pred_rd];
                    r.accepted    = 1'b1;
                    r.event_valid = 1'b1;
                    r.out_stream  = e.stream;
                    r.out_seq     = e.seq;
                    r.out_time    = e.time_ns;
                    r.out_kind    = e.kind;
                    r.out_flags   = e.flags;
                    r.out_reason  = e.reason;
                    r.out_value_a = e.value_a;
                    r.out_value_b = e.value_b;
                    r.out_value_c = e.value_c;
                    pred_rd = advance_ptr(pred_rd);
                    n_delivered++;
                end
            end
            efds_pkg::OP_SUMMARY:
            begin
                if (pred_drops_pend != 64'd0)
                begin
                    pred_seq = pred_seq + 64'd1;
                    r.accepted    = 1'b1;
                    r.event_valid = 1'b1;
                    r.out_stream  = pred_stream;
                    r.out_seq     = pred_seq;
                    r.out_time    = it.time_ns;
                    r.out_kind    = pred_sum_kind;
                    r.out_flags   = pred_lossy;
                    r.out_reason  = pred_warn;
                    r.out_value_a = pred_drops_pend;
                    r.out_value_b = pred_drops_total;
                    r.out_value_c = {32'd0, it.lost_kind};
                    pred_drops_pend = '0;
                    n_summaries++;
                end
            end
            default: ;
        endcase
        r.dropped_total = pred_drops_total;
        return r;
    endfunction

    function automatic void apply_reg_write(logic [efds_pkg::CFG_IDX_W-1:0] idx,
                                            logic [31:0] val);
        case (idx)
            efds_pkg::CFG_ENABLED:      pred_enabled  = val[0];
            efds_pkg::CFG_STREAM_IDENT: pred_stream   = val;
            efds_pkg::CFG_CAPACITY:     pred_cap      = val[7:0];
            efds_pkg::CFG_SUMMARY_KIND: pred_sum_kind = val;
            efds_pkg::CFG_LOSSY_FLAG:   pred_lossy    = val;
            efds_pkg::CFG_WARNING:      pred_warn     = val;
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    function automatic logic [63:0] field_value(int fill);
        logic [63:0] v;
        if (fill == FILL_ZERO)
            return '0;
        if (fill == FILL_ONES)
            return '1;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [31:0] reg_value();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = '0;
            1: v = '1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic efds_pkg::in_item_t make_item(efds_pkg::op_t op, int fill);
        efds_pkg::in_item_t it;
        it.op        = op;
        it.time_ns   = field_value(fill);
        it.kind      = 32'(field_value(fill));
        it.flag_bits = 32'(field_value(fill));
        it.reason    = 32'(field_value(fill));
        it.value_a   = field_value(fill);
        it.value_b   = field_value(fill);
        it.value_c   = field_value(fill);
        it.lost_kind = 32'(field_value(fill));
        return it;
    endfunction

    function automatic efds_pkg::op_t random_op(int pub_w, int pop_w, int sum_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < pub_w)
            return efds_pkg::OP_PUBLISH;
        if (r < pub_w + pop_w)
            return efds_pkg::OP_POP;
        if (r < pub_w + pop_w + sum_w)
            return efds_pkg::OP_SUMMARY;
        return efds_pkg::OP_UNUSED;
    endfunction

    function automatic int send_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic wait_all_done();
        while (pending_items.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [efds_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg_write(idx, val);
        n_reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // pop every held event so a capacity change never exposes an unwritten slot
    task automatic empty_store();
        logic [7:0] p;
        int         held;
        held = 0;
        p = pred_rd;
        while (p != pred_wr && held < efds_pkg::SLOTS)
        begin
            p = advance_ptr(p);
            held++;
        end
        if (held > 0)
        begin
            if (!pred_enabled)
                write_reg(efds_pkg::CFG_ENABLED, 32'd1);
            repeat (held)
                queue_item(make_item(efds_pkg::OP_POP, FILL_RAND));
            wait_all_done();
        end
    endtask

    task automatic set_capacity(logic [7:0] cap);
        logic [31:0] v;
        if (cap != pred_cap)
            empty_store();
        v = $urandom;
        v[7:0] = cap;
        write_reg(efds_pkg::CFG_CAPACITY, v);
    endtask

    // monitor: item acceptance and prediction, result checking, run limit
    always @(posedge clk)
    begin : mon
        efds_pkg::result_t got;
        efds_pkg::result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            if (rst_n && s_tvalid && s_tready)
            begin
                want = apply_event_item(
                    efds_pkg::in_item_t'(s_tdata[efds_pkg::IN_BITS-1:0]));
                expected_events = {expected_events, want};
                item_taken = 1'b1;
                n_items++;
            end
            if (rst_n && m_tvalid && m_tready)
            begin
                got = efds_pkg::result_t'(m_tdata[efds_pkg::RES_BITS-1:0]);
                if (expected_events.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %h", $time, got);
                    n_errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("accepted", 64'(want.accepted), 64'(got.accepted));
                    check_field("event_valid", 64'(want.event_valid), 64'(got.event_valid));
                    check_field("out_stream", 64'(want.out_stream), 64'(got.out_stream));
                    check_field("out_seq", want.out_seq, got.out_seq);
                    check_field("out_time", want.out_time, got.out_time);
                    check_field("out_kind", 64'(want.out_kind), 64'(got.out_kind));
                    check_field("out_flags", 64'(want.out_flags), 64'(got.out_flags));
                    check_field("out_reason", 64'(want.out_reason), 64'(got.out_reason));
                    check_field("out_value_a", want.out_value_a, got.out_value_a);
                    check_field("out_value_b", want.out_value_b, got.out_value_b);
                    check_field("out_value_c", want.out_value_c, got.out_value_c);
                    check_field("dropped_total", want.dropped_total, got.dropped_total);
                end
            end
        end
    end

    always @(negedge clk)
    begin : drv
        logic [efds_pkg::IN_DATA_W-1:0] word;
        if (!s_tvalid || item_taken)
        begin
            item_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                word = '0;
                word[efds_pkg::IN_BITS-1:0] = pending_items.pop_front();
                s_tdata  <= word;
                s_tvalid <= 1'b1;
                gap_left = send_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : rcv
        int r;
        if (hold_request > 0)
        begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (no_idle)
            m_tready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                stall_left = $urandom_range(10, 40);
                m_tready <= 1'b0;
            end
            else if (r < 25)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int            rand_count;
        int            phase;
        int            n;
        int            style;
        int            pub_w;
        int            pop_w;
        logic [7:0]    cap;
        logic [31:0]   v;
        efds_pkg::op_t op;

        rand_count = 0;
        phase = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // out of reset the queue is disabled: all items fail
        queue_item(make_item(efds_pkg::OP_PUBLISH, FILL_ONES));
        queue_item(make_item(efds_pkg::OP_POP, FILL_RAND));
        queue_item(make_item(efds_pkg::OP_SUMMARY, FILL_ONES));
        wait_all_done();

        write_reg(CFG_UNMAPPED, '1);
        write_reg(efds_pkg::CFG_ENABLED, 32'd1);
        write_reg(efds_pkg::CFG_STREAM_IDENT, '1);
        write_reg(efds_pkg::CFG_CAPACITY, 32'd4);
        write_reg(efds_pkg::CFG_SUMMARY_KIND, '0);
        write_reg(efds_pkg::CFG_LOSSY_FLAG, '1);
        write_reg(efds_pkg::CFG_WARNING, $urandom);

        // empty pop, summary with nothing pending, unused op
        queue_item(make_item(efds_pkg::OP_POP, FILL_RAND));
        queue_item(make_item(efds_pkg::OP_SUMMARY, FILL_RAND));
        queue_item(make_item(efds_pkg::OP_UNUSED, FILL_ONES));
        // fill a store of four, the fifth publish is dropped
        queue_item(make_item(efds_pkg::OP_PUBLISH, FILL_ONES));
        queue_item(make_item(efds_pkg::OP_PUBLISH, FILL_ZERO));
        queue_item(make_item(efds_pkg::OP_PUBLISH, FILL_RAND));
        queue_item(make_item(efds_pkg::OP_PUBLISH, FILL_RAND));
        queue_item(make_item(efds_pkg::OP_PUBLISH, FILL_RAND));
        queue_item(make_item(efds_pkg::OP_SUMMARY, FILL_ONES));
        queue_item(make_item(efds_pkg::OP_SUMMARY, FILL_RAND));
        repeat (5)
            queue_item(make_item(efds_pkg::OP_POP, FILL_RAND));
        // pointers reach the capacity and wrap back to zero
        repeat (2)
        begin
            queue_item(make_item(efds_pkg::OP_PUBLISH, FILL_RAND));
            queue_item(make_item(efds_pkg::OP_POP, FILL_RAND));
        end
        wait_all_done();

        set_capacity(8'd0);
        queue_item(make_item(efds_pkg::OP_PUBLISH, FILL_RAND));
        queue_item(make_item(efds_pkg::OP_POP, FILL_RAND));
        queue_item(make_item(efds_pkg::OP_SUMMARY, FILL_RAND));

        while (rand_count < RANDOM_ITEMS)
        begin
            wait_all_done();
            if (phase == 0)
                cap = 8'd255;
            else if (phase == 1)
                cap = 8'd2;
            else
            begin
                case ($urandom_range(0, 9))
                    0: cap = 8'd0;
                    1: cap = 8'd1;
                    2: cap = 8'd2;
                    3: cap = 8'd3;
                    4: cap = 8'd255;
                    5, 6, 7: cap = 8'($urandom_range(4, 16));
                    8: cap = 8'($urandom_range(17, 254));
                    default: cap = pred_cap;
                endcase
            end
            set_capacity(cap);
            v = $urandom;
            v[0] = (phase < 2) || ($urandom_range(0, 9) != 0);
            write_reg(efds_pkg::CFG_ENABLED, v);
            if ($urandom_range(0, 1))
                write_reg(efds_pkg::CFG_STREAM_IDENT, reg_value());
            if ($urandom_range(0, 1))
                write_reg(efds_pkg::CFG_SUMMARY_KIND, reg_value());
            if ($urandom_range(0, 1))
                write_reg(efds_pkg::CFG_LOSSY_FLAG, reg_value());
            if ($urandom_range(0, 1))
                write_reg(efds_pkg::CFG_WARNING, reg_value());

            no_idle = ($urandom_range(0, 4) == 0);
            if (phase == 0)
            begin
                // overfill the largest store while the output is held off
                no_idle = 1'b1;
                hold_request = 400;
                repeat (270)
                    queue_item(make_item(efds_pkg::OP_PUBLISH, FILL_RAND));
                queue_item(make_item(efds_pkg::OP_SUMMARY, FILL_RAND));
                repeat (260)
                    queue_item(make_item(efds_pkg::OP_POP, FILL_RAND));
                n = 531;
            end
            else
            begin
                style = $urandom_range(0, 2);
                pub_w = (style == 0) ? 45 : (style == 1) ? 75 : 25;
                pop_w = (style == 0) ? 35 : (style == 1) ? 10 : 60;
                n = $urandom_range(40, 150);
                repeat (n)
                begin
                    op = random_op(pub_w, pop_w, 100 - pub_w - pop_w - 4);
                    queue_item(make_item(op, FILL_RAND));
                end
            end
            rand_count += n;
            phase++;
        end

        wait_all_done();
        repeat (10) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_events.size());
            n_errors++;
        end
        $display("covered %0d items in %0d phases with %0d register writes",
                 n_items, phase, n_reg_writes);
        $display("%0d events stored, %0d popped, %0d drop summaries, %0d publishes lost",
                 n_stored, n_delivered, n_summaries, pred_drops_total);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> event_fifo_with_drop_summary_unit.f
rtl/efds_pkg.sv
rtl/efds_ram.sv
rtl/efds_cfg_regs.sv
rtl/efds_core.sv
rtl/event_fifo_with_drop_summary_unit.sv
dv/tb.sv
